[sv/poq_pkg.sv]
// Shared types, constants and command/status structs for the objective queue.
`default_nettype none

package poq_pkg;

	// Queue geometry.
	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int PRIO_W = 7;
	localparam int PAY_W  = 16;
	localparam int POS_W  = 4;
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_PEEK   = 2'd1,
		ACT_TAKE   = 2'd2,
		ACT_FLUSH  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NEG   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		action_t            action;
		logic signed [7:0]  priority_req;
		logic [PAY_W-1:0]   payload;
		logic [POS_W-1:0]   position;
	} poq_req_t;

	typedef struct packed {
		status_t            status;
		logic [PAY_W-1:0]   out_payload;
		logic [PRIO_W-1:0]  out_priority;
		logic [4:0]         count;
		logic [PRIO_W-1:0]  head_priority;
	} poq_rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load_item;
		logic             clear_res;
		logic             set_status;
		status_t          status;
		logic             grab_res;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic             wr_new;
		logic             count_inc;
		logic             count_dec;
		logic             count_clr;
		logic             head_clr;
		logic             out_load;
	} poq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		action_t          action;
		logic             prio_neg;
		logic [CNT_W-1:0] count;
		logic [POS_W-1:0] position;
		logic             rd_lower;
		logic             slot_free;
	} poq_stat_t;

endpackage

`default_nettype wire

[sv/poq_req_if.sv]
// Request channel carrying one queue action per beat.
`default_nettype none

interface poq_req_if import poq_pkg::*; ();
	logic     valid;
	logic     ready;
	poq_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/poq_rsp_if.sv]
// Response channel carrying one result per beat.
`default_nettype none

interface poq_rsp_if import poq_pkg::*; ();
	logic     valid;
	logic     ready;
	poq_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/poq_datapath.sv]
// Entry memories, item and result registers, count and head tracking.
`default_nettype none

module poq_datapath import poq_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire poq_req_t req_data,
	input  wire logic     rsp_ready,
	output logic          rsp_valid,
	output poq_rsp_t      rsp_data,
	input  wire poq_cmd_t cmd,
	output poq_stat_t     stat
);

	logic [PRIO_W-1:0] prio_mem [DEPTH];
	logic [PAY_W-1:0]  pay_mem [DEPTH];

	poq_req_t          item_q;
	logic [PRIO_W-1:0] rd_prio_q;
	logic [PAY_W-1:0]  rd_pay_q;
	logic [CNT_W-1:0]  count_q;
	logic [PRIO_W-1:0] head_q;
	status_t           res_status_q;
	logic [PAY_W-1:0]  res_payload_q;
	logic [PRIO_W-1:0] res_priority_q;
	poq_rsp_t          out_q;
	logic              out_valid_q;

	logic [PRIO_W-1:0] new_prio;
	logic [PRIO_W-1:0] wr_prio;
	logic [PAY_W-1:0]  wr_pay;

	assign new_prio = item_q.priority_req[PRIO_W-1:0];
	assign wr_prio  = cmd.wr_new ? new_prio : rd_prio_q;
	assign wr_pay   = cmd.wr_new ? item_q.payload : rd_pay_q;

	// Entry storage: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			prio_mem[cmd.wr_addr] <= wr_prio;
			pay_mem[cmd.wr_addr]  <= wr_pay;
		end
		if (cmd.rd_en) begin
			rd_prio_q <= prio_mem[cmd.rd_addr];
			rd_pay_q  <= pay_mem[cmd.rd_addr];
		end
	end

	// Captured item and the result being built for it. A status set while the
	// result is cleared is kept, since the error checks run at dispatch.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= req_data;
		end
		if (cmd.clear_res) begin
			res_status_q   <= cmd.set_status ? cmd.status : ST_OK;
			res_payload_q  <= '0;
			res_priority_q <= '0;
		end else begin
			if (cmd.set_status) begin
				res_status_q <= cmd.status;
			end
			if (cmd.grab_res) begin
				res_payload_q  <= rd_pay_q;
				res_priority_q <= rd_prio_q;
			end
		end
	end

	// Pending count and head priority. A write to the head slot sets the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
		end else begin
			if (cmd.count_clr) begin
				count_q <= '0;
			end else if (cmd.count_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.head_clr) begin
				head_q <= '0;
			end else if (cmd.wr_en && (cmd.wr_addr == '0)) begin
				head_q <= wr_prio;
			end
		end
	end

	// Output register; it holds a result until the receiver takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.status        <= res_status_q;
			out_q.out_payload   <= res_payload_q;
			out_q.out_priority  <= res_priority_q;
			out_q.count         <= 5'(count_q);
			out_q.head_priority <= head_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	// Status back to the controller.
	always_comb begin
		stat.action    = item_q.action;
		stat.prio_neg  = item_q.priority_req[7];
		stat.count     = count_q;
		stat.position  = item_q.position;
		stat.rd_lower  = (rd_prio_q < new_prio);
		stat.slot_free = !out_valid_q || rsp_ready;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("pending count exceeds queue depth");

	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == '0))
		else $error("empty queue reports a nonzero head priority");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || rsp_ready))
		else $error("result loaded over a beat not yet taken");

endmodule

`default_nettype wire

[sv/poq_ctrl.sv]
// Controller state machine that sequences the walk and shift over the entries.
`default_nettype none

module poq_ctrl import poq_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire poq_stat_t stat,
	output poq_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_WALK,
		S_PLACE,
		S_PEEK,
		S_GRAB,
		S_SHIFT,
		S_FINISH
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cur_q, cur_d;
	logic [CNT_W-1:0] place_q, place_d;

	logic [CNT_W-1:0] cur_prev;
	logic [CNT_W-1:0] cur_next;
	logic [CNT_W-1:0] count_m1;
	logic             pos_out;

	assign cur_prev = cur_q - CNT_W'(1);
	assign cur_next = cur_q + CNT_W'(1);
	assign count_m1 = stat.count - CNT_W'(1);
	assign pos_out  = CMP_W'(stat.position) >= CMP_W'(stat.count);
	assign req_ready = (state_q == S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cur_d   = cur_q;
		place_d = place_q;
		cmd     = '0;
		cmd.status = ST_OK;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.clear_res = 1'b1;
				unique case (stat.action)
					ACT_INSERT: begin
						if (stat.prio_neg) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_NEG;
							state_d = S_FINISH;
						end else if (stat.count == CNT_W'(DEPTH)) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_FULL;
							state_d = S_FINISH;
						end else if (stat.count == '0) begin
							place_d = '0;
							state_d = S_PLACE;
						end else begin
							cmd.rd_en = 1'b1;
							cmd.rd_addr = IDX_W'(count_m1);
							cur_d = count_m1;
							state_d = S_WALK;
						end
					end
					ACT_PEEK: begin
						if (stat.count == '0) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_EMPTY;
							state_d = S_FINISH;
						end else begin
							cmd.rd_en = 1'b1;
							cmd.rd_addr = '0;
							state_d = S_PEEK;
						end
					end
					ACT_TAKE: begin
						if (pos_out) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_EMPTY;
							state_d = S_FINISH;
						end else begin
							cmd.rd_en = 1'b1;
							cmd.rd_addr = IDX_W'(stat.position);
							cur_d = CNT_W'(stat.position) + CNT_W'(1);
							state_d = S_GRAB;
						end
					end
					ACT_FLUSH: begin
						if (stat.count == '0) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_EMPTY;
						end
						cmd.count_clr = 1'b1;
						cmd.head_clr = 1'b1;
						state_d = S_FINISH;
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			// Walk from the tail toward the head, moving lower entries back one slot.
			S_WALK: begin
				if (stat.rd_lower) begin
					cmd.wr_en = 1'b1;
					cmd.wr_addr = IDX_W'(cur_next);
					if (cur_q == '0) begin
						place_d = '0;
						state_d = S_PLACE;
					end else begin
						cmd.rd_en = 1'b1;
						cmd.rd_addr = IDX_W'(cur_prev);
						cur_d = cur_prev;
					end
				end else begin
					place_d = cur_next;
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = IDX_W'(place_q);
				cmd.wr_new = 1'b1;
				cmd.count_inc = 1'b1;
				state_d = S_FINISH;
			end
			S_PEEK: begin
				cmd.grab_res = 1'b1;
				state_d = S_FINISH;
			end
			// The taken entry is in the read register; start closing the gap.
			S_GRAB: begin
				cmd.grab_res = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_addr = IDX_W'(cur_q);
				if (cur_q < stat.count) begin
					state_d = S_SHIFT;
				end else begin
					cmd.count_dec = 1'b1;
					cmd.head_clr = (stat.count == CNT_W'(1));
					state_d = S_FINISH;
				end
			end
			S_SHIFT: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = IDX_W'(cur_prev);
				if (cur_q == count_m1) begin
					cmd.count_dec = 1'b1;
					state_d = S_FINISH;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_addr = IDX_W'(cur_next);
					cur_d = cur_next;
				end
			end
			S_FINISH: begin
				if (stat.slot_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and walk index registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
			place_q <= '0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			place_q <= place_d;
		end
	end

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_DISPATCH))
		else $error("accepted beat not dispatched");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK || state_q == S_SHIFT) |-> (cur_q < stat.count))
		else $error("walk index outside occupied entries");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (state_q == S_WALK || state_q == S_PLACE || state_q == S_SHIFT))
		else $error("entry write outside a walk, shift or placement");

endmodule

`default_nettype wire

[sv/priority_ordered_objective_queue_core.sv]
// Top level of the priority-ordered objective queue.
// Holds up to DEPTH (16) entries of a 7-bit priority and a 16-bit payload tag,
// ordered so that higher priority sits nearer the head, ties in arrival order.
// The request channel carries one action per beat: insert, peek at the head,
// take the entry at a position (closing the gap), or flush. Each request
// produces exactly one response beat with status, the entry read, the
// pending count and the head priority after the action.
// One request is worked on at a time; request ready is high only while idle.
// The entry memory gives one registered read and one write per cycle, so the
// walk and the shift move one entry per cycle. A finished response waits in
// the output register while the receiver stalls; the next request may be
// accepted meanwhile and completes once that beat has been taken. Reset
// empties the queue (count and head priority zero); the entry memory is not
// cleared, and only occupied slots feed a result or a shifted entry.
`default_nettype none

module priority_ordered_objective_queue_core import poq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	poq_req_if.sink   request,
	poq_rsp_if.source response
);

	poq_cmd_t  cmd;
	poq_stat_t stat;

	// Sequencer.
	poq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage and result path.
	poq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (request.data),
		.rsp_ready (response.ready),
		.rsp_valid (response.valid),
		.rsp_data  (response.data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire

[sim/priority_ordered_objective_queue_core_tb.sv]
// Self-checking testbench for the priority-ordered objective queue core.
`default_nettype none

module priority_ordered_objective_queue_core_tb;
	import poq_pkg::*;

	localparam int RAND_ITEMS = 1525;
	localparam int CALM_ITEMS = 200;
	localparam int LONG_HOLD  = 400;
	localparam int DRAIN_WAIT = 40;

	typedef struct {
		poq_req_t req;
		bit       typed;
		poq_rsp_t want;
	} step_row_t;

	logic clk;
	logic arst_n;

	poq_req_if req_ch ();
	poq_rsp_if rsp_ch ();

	priority_ordered_objective_queue_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (req_ch),
		.response (rsp_ch)
	);

	// Shadow copy of the sorted queue.
	logic [PRIO_W-1:0] shadow_prio [DEPTH];
	logic [PAY_W-1:0]  shadow_tag [DEPTH];
	int                shadow_count;
	logic [PRIO_W-1:0] shadow_head;

	poq_rsp_t  awaited_beats [$];
	step_row_t directed_steps [$];
	int        errors;
	bit        calm;
	bit        long_hold_req;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Applies one action to the shadow queue and returns the response beat it must produce.
	function automatic poq_rsp_t queue_outcome(poq_req_t r);
		poq_rsp_t res;
		int slot;
		int k;
		res = '0;
		res.status = ST_OK;
		case (r.action)
			ACT_INSERT: begin
				if (r.priority_req[7]) begin
					res.status = ST_NEG;
				end else if (shadow_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					// New entry goes behind every entry of equal or higher priority.
					slot = shadow_count;
					while (slot > 0 && shadow_prio[slot-1] < r.priority_req[6:0])
						slot--;
					for (k = shadow_count; k > slot; k--) begin
						shadow_prio[k] = shadow_prio[k-1];
						shadow_tag[k]  = shadow_tag[k-1];
					end
					shadow_prio[slot] = r.priority_req[6:0];
					shadow_tag[slot]  = r.payload;
					shadow_count++;
				end
			end
			ACT_PEEK: begin
				if (shadow_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.out_payload  = shadow_tag[0];
					res.out_priority = shadow_prio[0];
				end
			end
			ACT_TAKE: begin
				if (int'(r.position) >= shadow_count) begin
					res.status = ST_EMPTY;
				end else begin
					res.out_payload  = shadow_tag[r.position];
					res.out_priority = shadow_prio[r.position];
					for (k = r.position; k + 1 < shadow_count; k++) begin
						shadow_prio[k] = shadow_prio[k+1];
						shadow_tag[k]  = shadow_tag[k+1];
					end
					shadow_count--;
				end
			end
			default: begin
				if (shadow_count == 0)
					res.status = ST_EMPTY;
				shadow_count = 0;
			end
		endcase
		shadow_head = (shadow_count > 0) ? shadow_prio[0] : '0;
		res.count = shadow_count[4:0];
		res.head_priority = shadow_head;
		return res;
	endfunction

	function automatic poq_req_t make_req(action_t a, int prio, int tag, int pos);
		poq_req_t r;
		r.action       = a;
		r.priority_req = prio[7:0];
		r.payload      = tag[PAY_W-1:0];
		r.position     = pos[POS_W-1:0];
		return r;
	endfunction

	function automatic poq_rsp_t make_rsp(status_t s, int tag, int prio, int cnt, int head);
		poq_rsp_t r;
		r.status        = s;
		r.out_payload   = tag[PAY_W-1:0];
		r.out_priority  = prio[PRIO_W-1:0];
		r.count         = cnt[4:0];
		r.head_priority = head[PRIO_W-1:0];
		return r;
	endfunction

	task automatic add_step(poq_req_t r, bit typed = 1'b0, poq_rsp_t want = '0);
		step_row_t row;
		row.req   = r;
		row.typed = typed;
		row.want  = want;
		directed_steps.push_back(row);
	endtask

	// Offers one request beat, with an optional idle burst ahead of it, and records the result.
	task automatic offer(poq_req_t r, bit typed, poq_rsp_t want, bit may_idle);
		poq_rsp_t predicted;
		int gap;
		gap = (may_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
		if (gap != 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do @(posedge clk); while (!req_ch.ready);
		predicted = queue_outcome(r);
		awaited_beats.push_back(typed ? want : predicted);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			errors++;
		end
	endtask

	// Response side: random stall bursts, one long hold-off on request, none at the end.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				rsp_ch.ready <= 1'b1;
			end else if (calm || $urandom_range(0, 7) != 0) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(negedge clk);
			end
		end
	end

	// Every accepted response beat is matched against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_beats.size() == 0) begin
				$error("response beat with no request outstanding");
				errors++;
			end else begin
				poq_rsp_t want;
				want = awaited_beats.pop_front();
				check_field("status", want.status, rsp_ch.data.status);
				check_field("out_payload", want.out_payload, rsp_ch.data.out_payload);
				check_field("out_priority", want.out_priority, rsp_ch.data.out_priority);
				check_field("count", want.count, rsp_ch.data.count);
				check_field("head_priority", want.head_priority, rsp_ch.data.head_priority);
			end
		end
	end

	// Stimulus.
	initial begin
		poq_req_t r;
		int roll;
		int prio;
		int pos;
		bit fill_phase;
		bit may_idle;

		errors        = 0;
		calm          = 1'b0;
		long_hold_req = 1'b0;
		shadow_count  = 0;
		shadow_head   = '0;
		req_ch.valid  = 1'b0;
		req_ch.data   = '0;
		arst_n        = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed steps: empty-queue errors, rejected priorities, ties, range edge, full queue.
		add_step(make_req(ACT_PEEK, 0, 0, 0), 1, make_rsp(ST_EMPTY, 0, 0, 0, 0));
		add_step(make_req(ACT_FLUSH, 0, 0, 0), 1, make_rsp(ST_EMPTY, 0, 0, 0, 0));
		add_step(make_req(ACT_INSERT, -128, 16'hffff, 0), 1, make_rsp(ST_NEG, 0, 0, 0, 0));
		add_step(make_req(ACT_INSERT, -1, 16'h00ff, 15), 1, make_rsp(ST_NEG, 0, 0, 0, 0));
		add_step(make_req(ACT_INSERT, 0, 0, 0), 1, make_rsp(ST_OK, 0, 0, 1, 0));
		add_step(make_req(ACT_INSERT, 127, 16'hffff, 0), 1, make_rsp(ST_OK, 0, 0, 2, 127));
		add_step(make_req(ACT_INSERT, 127, 16'h1234, 0), 1, make_rsp(ST_OK, 0, 0, 3, 127));
		add_step(make_req(ACT_PEEK, 0, 0, 0), 1, make_rsp(ST_OK, 16'hffff, 127, 3, 127));
		add_step(make_req(ACT_INSERT, 64, 16'h5555, 0));
		add_step(make_req(ACT_TAKE, 0, 0, 1));
		// Position equal to the count is out of range.
		add_step(make_req(ACT_TAKE, 0, 0, 3), 1, make_rsp(ST_EMPTY, 0, 0, 3, 127));
		add_step(make_req(ACT_TAKE, 0, 0, 15), 1, make_rsp(ST_EMPTY, 0, 0, 3, 127));
		for (int k = 1; k <= 13; k++)
			add_step(make_req(ACT_INSERT, (k * 37) % 128, k * 4111, 0));
		add_step(make_req(ACT_INSERT, 5, 16'haaaa, 0), 1, make_rsp(ST_FULL, 0, 0, 16, 127));
		add_step(make_req(ACT_TAKE, 0, 0, 15));
		add_step(make_req(ACT_FLUSH, 0, 0, 0), 1, make_rsp(ST_OK, 0, 0, 0, 0));

		foreach (directed_steps[i])
			offer(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].want, 1'b1);

		// Random part: alternating fill-leaning and drain-leaning stretches.
		for (int i = 0; i < RAND_ITEMS; i++) begin
			fill_phase = ((i / 64) % 2) == 0;
			roll = $urandom_range(0, 99);
			if (fill_phase)
				r.action = (roll < 70) ? ACT_INSERT : (roll < 78) ? ACT_PEEK :
					(roll < 97) ? ACT_TAKE : ACT_FLUSH;
			else
				r.action = (roll < 30) ? ACT_INSERT : (roll < 40) ? ACT_PEEK :
					(roll < 98) ? ACT_TAKE : ACT_FLUSH;

			// Mostly legal priorities, with ties clustered at the top and mid range.
			roll = $urandom_range(0, 9);
			if (roll == 0)
				prio = $urandom_range(128, 255);
			else if (roll < 4)
				prio = $urandom_range(0, 1) ? 127 : $urandom_range(40, 43);
			else
				prio = $urandom_range(0, 127);
			r.priority_req = prio[7:0];
			r.payload = $urandom_range(0, 65535);

			if (r.action == ACT_TAKE && shadow_count > 0 && $urandom_range(0, 3) != 0)
				pos = $urandom_range(0, shadow_count - 1);
			else
				pos = $urandom_range(0, 15);
			r.position = pos[POS_W-1:0];

			// Long response hold-off midway; the sender keeps offering so the core backs up.
			if (i == RAND_ITEMS / 2)
				long_hold_req = 1'b1;
			if (i == RAND_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			may_idle = !calm && !(i >= RAND_ITEMS / 2 && i < RAND_ITEMS / 2 + 12);
			offer(r, 1'b0, '0, may_idle);
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;

		// Let every outstanding response beat arrive, then watch for strays.
		while (awaited_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
